// ----- rtl/alo_pkg.sv -----
// Package with shared constants and types for the audio looper.
package alo_pkg;

  localparam int STORE_DEPTH_DEF  = 1048576;
  localparam int MAX_DUBS_DEF     = 128;
  localparam int FADE_SAMPLES_DEF = 64;

  localparam int SAMPLE_W  = 24;
  localparam int CMD_W     = 3;
  localparam int MODE_W    = 2;
  localparam int COUNT_W   = 8;
  localparam int THRESH_W  = 23;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 23;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SAMPLE_W + FRAC_W + 1;
  localparam int ACC_W     = 34;

  localparam logic [CMD_W-1:0] CMD_SAMPLE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ACTIVATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNDO     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REDO     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUB      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

  localparam logic [MODE_W-1:0] MODE_INACTIVE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WAITING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECORDING = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PLAYING   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN  = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ----- rtl/alo_stream_if.sv -----
// Request channel interfaces for looper input items and result items.
interface alo_in_if;
  import alo_pkg::*;
  logic valid;
  logic ready;
  logic [CMD_W-1:0] command;
  sample_t in_left;
  sample_t in_right;
  modport source (output valid, command, in_left, in_right, input ready);
  modport sink (input valid, command, in_left, in_right, output ready);
endinterface

interface alo_out_if;
  import alo_pkg::*;
  logic valid;
  logic ready;
  sample_t out_left;
  sample_t out_right;
  logic [MODE_W-1:0] looper_mode;
  logic [COUNT_W-1:0] active_dubs;
  modport source (output valid, out_left, out_right, looper_mode, active_dubs, input ready);
  modport sink (input valid, out_left, out_right, looper_mode, active_dubs, output ready);
endinterface

// ----- rtl/audio_looper_overdub_top.sv -----
// Stereo looper with overdub, undo and redo, run by a multi-cycle sequencer.
//
// Channel   Direction  Carries
// samples   sink       command, in_left, in_right
// results   source     out_left, out_right, looper_mode, active_dubs
// wr_*      write      threshold (index 0), dry_gain (index 1)
//
// A sample request applies the dry gain, then walks every dub and adds the stored sample of each
// dub heard; an inactive looper skips the walk. A wrap that ends a recording adds the fade.
// Finishing a dub fades it in and out, each fade step set by the serial divider and multiplier.
// Commands that end a recording add its fade as well.
// Reset is synchronous and clears the looper state at once.
// A new request is taken while a result still waits; it completes once the result is taken.
module audio_looper_overdub_top #(
  parameter int STORE_DEPTH  = alo_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DUBS     = alo_pkg::MAX_DUBS_DEF,
  parameter int FADE_SAMPLES = alo_pkg::FADE_SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  alo_in_if.sink                       samples,
  alo_out_if.source                    results,
  input  logic                         wr_en,
  input  logic [alo_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [alo_pkg::CFG_W-1:0]    wr_data
);
  import alo_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = $clog2(STORE_DEPTH + 2);
  localparam int DW = (MAX_DUBS > 1) ? $clog2(MAX_DUBS) : 1;
  localparam int CW = $clog2(FADE_SAMPLES + 1);
  localparam int KW = $clog2(FRAC_W);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_SMP   = 5'd2;
  localparam logic [4:0] S_DRYL  = 5'd3;
  localparam logic [4:0] S_DRYR  = 5'd4;
  localparam logic [4:0] S_DRYR2 = 5'd5;
  localparam logic [4:0] S_WALK  = 5'd6;
  localparam logic [4:0] S_WALK2 = 5'd7;
  localparam logic [4:0] S_WALK3 = 5'd8;
  localparam logic [4:0] S_WALK4 = 5'd9;
  localparam logic [4:0] S_POS   = 5'd10;
  localparam logic [4:0] S_FIN   = 5'd11;
  localparam logic [4:0] S_FSET  = 5'd12;
  localparam logic [4:0] S_FDIV  = 5'd13;
  localparam logic [4:0] S_FADR  = 5'd14;
  localparam logic [4:0] S_FWAIT = 5'd15;
  localparam logic [4:0] S_FML   = 5'd16;
  localparam logic [4:0] S_FMR   = 5'd17;
  localparam logic [4:0] S_FWR   = 5'd18;
  localparam logic [4:0] S_RET   = 5'd19;
  localparam logic [4:0] S_ARM   = 5'd20;
  localparam logic [4:0] S_UNDO  = 5'd21;
  localparam logic [4:0] S_UNDO2 = 5'd22;
  localparam logic [4:0] S_REDO  = 5'd23;
  localparam logic [4:0] S_REDO2 = 5'd24;
  localparam logic [4:0] S_OUT   = 5'd25;

  localparam logic [1:0] RET_OUT   = 2'd0;
  localparam logic [1:0] RET_ARM   = 2'd1;
  localparam logic [1:0] RET_ARMIF = 2'd2;
  localparam logic [1:0] RET_UNDO  = 2'd3;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);

  logic [4:0] state;
  logic [1:0] ret;
  logic [MODE_W-1:0] mode;
  logic [PW-1:0] loop_position;
  logic [PW-1:0] loop_length;
  logic [PW-1:0] used_samples;
  logic [COUNT_W-1:0] dub_count;
  logic [COUNT_W-1:0] redo_limit;
  logic [THRESH_W-1:0] threshold;
  logic [GAIN_W-1:0] dry_gain;

  logic [CMD_W-1:0] cmd;
  sample_t smp_l;
  sample_t smp_r;
  logic [PW-1:0] rec_off;
  logic [PW-1:0] rec_len;
  logic [COUNT_W-1:0] walk_t;
  logic signed [ACC_W-1:0] acc_l;
  logic signed [ACC_W-1:0] acc_r;
  sample_t res_l;
  sample_t res_r;
  logic [CW-1:0] fade_cnt;
  logic [CW-1:0] fade_s;
  logic [CW-1:0] div_rem;
  logic [FRAC_W-1:0] fade_f;
  logic [KW-1:0] div_k;
  logic fade_phase;
  sample_t fade_l;
  logic [AW-1:0] store_addr;
  logic out_valid;

  logic [PW-1:0] dub_start_mem [MAX_DUBS];
  logic [PW-1:0] dub_offset_mem [MAX_DUBS];
  logic [PW-1:0] dub_length_mem [MAX_DUBS];
  sample_t store_left [STORE_DEPTH];
  sample_t store_right [STORE_DEPTH];

  logic [DW-1:0] dub_raddr;
  logic [PW-1:0] rd_start;
  logic [PW-1:0] rd_off;
  logic [PW-1:0] rd_len;
  logic we_start;
  logic we_off;
  logic we_len;
  logic [PW-1:0] wd_len;
  sample_t st_rd_l;
  sample_t st_rd_r;
  logic st_we;
  logic [AW-1:0] st_waddr;
  sample_t st_wl;
  sample_t st_wr;

  sample_t mul_a;
  logic [FRAC_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_dry;
  logic signed [PROD_W-1:0] prod_fade;
  logic signed [ACC_W-1:0] dry_val;
  sample_t fade_val;

  logic busy;
  logic [SAMPLE_W-1:0] mag_l;
  logic [SAMPLE_W-1:0] mag_r;
  logic start_rec;
  logic rec_now;
  logic [PW-1:0] pos_next;
  logic [PW:0] dub_end;
  logic dub_hit;
  logic [CW:0] div_r2;
  logic [PW-1:0] fade_addr;
  sample_t sat_l;
  sample_t sat_r;

  assign busy = (mode == MODE_RECORDING) || (mode == MODE_WAITING);
  assign mag_l = smp_l[SAMPLE_W-1] ? SAMPLE_W'(-smp_l) : SAMPLE_W'(smp_l);
  assign mag_r = smp_r[SAMPLE_W-1] ? SAMPLE_W'(-smp_r) : SAMPLE_W'(smp_r);
  assign start_rec = (mode == MODE_WAITING) && (dub_count < COUNT_W'(MAX_DUBS)) &&
                     ((mag_l >= SAMPLE_W'(threshold)) || (mag_r >= SAMPLE_W'(threshold)));
  assign rec_now = ((mode == MODE_RECORDING) || start_rec) &&
                   (dub_count < COUNT_W'(MAX_DUBS)) && (used_samples < PW'(STORE_DEPTH));
  assign pos_next = (dub_count != '0) ? loop_position + 1'b1 : loop_position;
  assign dub_end = {1'b0, rd_start} + {1'b0, rd_len};
  assign dub_hit = (loop_position >= rd_start) && ({1'b0, loop_position} < dub_end);
  assign div_r2 = {div_rem, 1'b0};
  assign fade_addr = fade_phase ? rec_off + rec_len - 1'b1 - PW'(fade_s) : rec_off + PW'(fade_s);

  assign prod_dry = prod + PROD_W'(16384);
  assign prod_fade = prod + PROD_W'(32768);
  assign dry_val = ACC_W'($signed(prod_dry[PROD_W-1:15]));
  assign fade_val = prod_fade[SAMPLE_W+FRAC_W-1:FRAC_W];

  always_comb begin
    sat_l = acc_l[SAMPLE_W-1:0];
    sat_r = acc_r[SAMPLE_W-1:0];
    if (acc_l > SAT_MAX) sat_l = SAT_MAX[SAMPLE_W-1:0];
    else if (acc_l < SAT_MIN) sat_l = SAT_MIN[SAMPLE_W-1:0];
    if (acc_r > SAT_MAX) sat_r = SAT_MAX[SAMPLE_W-1:0];
    else if (acc_r < SAT_MIN) sat_r = SAT_MIN[SAMPLE_W-1:0];
  end

  always_comb begin
    mul_a = smp_l;
    mul_b = dry_gain;
    case (state)
      S_DRYR:  mul_a = smp_r;
      S_FML: begin
        mul_a = st_rd_l;
        mul_b = fade_f;
      end
      S_FMR: begin
        mul_a = st_rd_r;
        mul_b = fade_f;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    dub_raddr = walk_t[DW-1:0];
    if (state == S_UNDO) dub_raddr = DW'(dub_count - 1'b1);
    else if (state == S_REDO) dub_raddr = dub_count[DW-1:0];
    we_start = (state == S_SMP) && start_rec;
    we_off = (state == S_ARM) && (dub_count < COUNT_W'(MAX_DUBS)) &&
             (used_samples < PW'(STORE_DEPTH));
    we_len = we_off || ((state == S_SMP) && rec_now);
    wd_len = we_off ? '0 : rec_len + 1'b1;
    st_we = ((state == S_SMP) && rec_now) || (state == S_FWR);
    st_waddr = (state == S_SMP) ? used_samples[AW-1:0] : store_addr;
    st_wl = (state == S_SMP) ? smp_l : fade_l;
    st_wr = (state == S_SMP) ? smp_r : fade_val;
  end

  always_ff @(posedge clk) begin
    if (we_start) dub_start_mem[dub_count[DW-1:0]] <= loop_position;
    if (we_off) dub_offset_mem[dub_count[DW-1:0]] <= used_samples;
    if (we_len) dub_length_mem[dub_count[DW-1:0]] <= wd_len;
    rd_start <= dub_start_mem[dub_raddr];
    rd_off <= dub_offset_mem[dub_raddr];
    rd_len <= dub_length_mem[dub_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_left[st_waddr] <= st_wl;
      store_right[st_waddr] <= st_wr;
    end
    st_rd_l <= store_left[store_addr];
    st_rd_r <= store_right[store_addr];
  end

  assign samples.ready = (state == S_IDLE);
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      dry_gain <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD: threshold <= wr_data[THRESH_W-1:0];
        REG_DRY_GAIN:  dry_gain <= wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= MODE_INACTIVE;
      loop_position <= '0;
      loop_length <= '0;
      used_samples <= '0;
      dub_count <= '0;
      redo_limit <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready && (state != S_OUT)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            cmd <= samples.command;
            smp_l <= samples.in_left;
            smp_r <= samples.in_right;
            res_l <= '0;
            res_r <= '0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd)
            CMD_SAMPLE: state <= (mode == MODE_INACTIVE) ? S_DRYL : S_SMP;
            CMD_ACTIVATE: begin
              ret <= RET_OUT;
              state <= busy ? S_FIN : S_ARM;
            end
            CMD_RESET: begin
              ret <= RET_OUT;
              state <= busy ? S_FIN : S_UNDO;
            end
            CMD_UNDO: begin
              ret <= RET_UNDO;
              state <= busy ? S_FIN : S_UNDO;
            end
            CMD_REDO: state <= S_REDO;
            CMD_DUB: begin
              ret <= RET_ARM;
              state <= busy ? S_FIN : S_ARM;
            end
            CMD_CLEAR: begin
              mode <= MODE_INACTIVE;
              loop_position <= '0;
              loop_length <= '0;
              used_samples <= '0;
              dub_count <= '0;
              redo_limit <= '0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_SMP: begin
          if (start_rec) mode <= MODE_RECORDING;
          if (rec_now) begin
            used_samples <= used_samples + 1'b1;
            rec_len <= rec_len + 1'b1;
          end
          state <= S_DRYL;
        end
        S_DRYL: state <= S_DRYR;
        S_DRYR: begin
          acc_l <= dry_val;
          state <= S_DRYR2;
        end
        S_DRYR2: begin
          acc_r <= dry_val;
          walk_t <= '0;
          state <= (mode == MODE_INACTIVE) ? S_POS : S_WALK;
        end
        S_WALK: begin
          if ((walk_t < dub_count) && (walk_t < COUNT_W'(MAX_DUBS))) state <= S_WALK2;
          else state <= S_POS;
        end
        S_WALK2: begin
          store_addr <= AW'(rd_off + (loop_position - rd_start));
          if (dub_hit) begin
            state <= S_WALK3;
          end else begin
            walk_t <= walk_t + 1'b1;
            state <= S_WALK;
          end
        end
        S_WALK3: state <= S_WALK4;
        S_WALK4: begin
          acc_l <= acc_l + ACC_W'(st_rd_l);
          acc_r <= acc_r + ACC_W'(st_rd_r);
          walk_t <= walk_t + 1'b1;
          state <= S_WALK;
        end
        S_POS: begin
          res_l <= sat_l;
          res_r <= sat_r;
          if ((mode != MODE_INACTIVE) &&
              ((pos_next > loop_length) || (used_samples >= PW'(STORE_DEPTH)))) begin
            loop_position <= '0;
            if (mode == MODE_RECORDING) begin
              ret <= RET_ARMIF;
              state <= S_FIN;
            end else begin
              state <= S_OUT;
            end
          end else begin
            if (mode != MODE_INACTIVE) loop_position <= pos_next;
            state <= S_OUT;
          end
        end
        S_FIN: begin
          if (mode == MODE_WAITING) begin
            mode <= (dub_count == '0) ? MODE_INACTIVE : MODE_PLAYING;
            state <= S_RET;
          end else begin
            mode <= MODE_PLAYING;
            if (dub_count == '0) begin
              loop_length <= rec_len;
              loop_position <= '0;
            end
            fade_cnt <= (rec_len > PW'(FADE_SAMPLES)) ? CW'(FADE_SAMPLES) : CW'(rec_len);
            fade_s <= '0;
            dub_count <= dub_count + 1'b1;
            redo_limit <= dub_count + 1'b1;
            state <= (rec_len == '0) ? S_RET : S_FSET;
          end
        end
        S_FSET: begin
          div_rem <= fade_s;
          fade_f <= '0;
          div_k <= '0;
          fade_phase <= 1'b0;
          state <= S_FDIV;
        end
        S_FDIV: begin
          if (div_r2 >= {1'b0, fade_cnt}) begin
            div_rem <= CW'(div_r2 - {1'b0, fade_cnt});
            fade_f <= {fade_f[FRAC_W-2:0], 1'b1};
          end else begin
            div_rem <= div_r2[CW-1:0];
            fade_f <= {fade_f[FRAC_W-2:0], 1'b0};
          end
          div_k <= div_k + 1'b1;
          if (div_k == KW'(FRAC_W - 1)) state <= S_FADR;
        end
        S_FADR: begin
          store_addr <= fade_addr[AW-1:0];
          state <= S_FWAIT;
        end
        S_FWAIT: state <= S_FML;
        S_FML: state <= S_FMR;
        S_FMR: begin
          fade_l <= fade_val;
          state <= S_FWR;
        end
        S_FWR: begin
          if (!fade_phase) begin
            fade_phase <= 1'b1;
            state <= S_FADR;
          end else begin
            fade_s <= fade_s + 1'b1;
            state <= (fade_s + 1'b1 < fade_cnt) ? S_FSET : S_RET;
          end
        end
        S_RET: begin
          unique case (ret)
            RET_OUT:   state <= S_OUT;
            RET_ARM:   state <= S_ARM;
            RET_ARMIF: state <= (dub_count > COUNT_W'(1)) ? S_ARM : S_OUT;
            RET_UNDO:  state <= S_UNDO;
            default:   state <= S_OUT;
          endcase
        end
        S_ARM: begin
          if (we_off) begin
            rec_off <= used_samples;
            rec_len <= '0;
            mode <= MODE_WAITING;
          end
          state <= S_OUT;
        end
        S_UNDO: begin
          if ((dub_count == '0) || (dub_count > COUNT_W'(MAX_DUBS))) begin
            state <= S_OUT;
          end else begin
            dub_count <= dub_count - 1'b1;
            state <= S_UNDO2;
          end
        end
        S_UNDO2: begin
          used_samples <= rd_off;
          if (dub_count == '0) begin
            loop_length <= '0;
            loop_position <= '0;
          end
          state <= S_OUT;
        end
        S_REDO: begin
          if (busy || (dub_count >= redo_limit) || (dub_count >= COUNT_W'(MAX_DUBS))) begin
            state <= S_OUT;
          end else begin
            state <= S_REDO2;
          end
        end
        S_REDO2: begin
          used_samples <= rd_off + rd_len;
          if (dub_count == '0) begin
            loop_position <= '0;
            loop_length <= rd_len;
          end
          dub_count <= dub_count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            results.out_left <= res_l;
            results.out_right <= res_r;
            results.looper_mode <= mode;
            results.active_dubs <= dub_count;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
